/* design/lpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants of the length-prefix deframer
// Message class codes, header constants and the result record that travels
// from the deframe step to the output register.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Byte and length widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 32;
  localparam int unsigned CntW  = 3;

  // Header is four bytes, big-endian
  localparam logic [CntW-1:0] HDR_LEN = 3'd4;

  // Reset value of the maximum payload length: 10 MiB
  localparam logic [LenW-1:0] RESET_MAX_LEN = 32'd10485760;

  // First-payload-byte type codes
  localparam logic [ByteW-1:0] TYPE_META  = 8'h01;
  localparam logic [ByteW-1:0] TYPE_CHUNK = 8'h02;

  typedef enum logic [1:0] {
    CLASS_META  = 2'd0,
    CLASS_CHUNK = 2'd1,
    CLASS_PLAIN = 2'd2
  } msg_class_e;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    msg_class_e       message_class;
    logic             first_of_message;
    logic             last_of_message;
    logic             too_large;
  } result_t;

endpackage

/* design/lpd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_in_stage: input register of the deframer
// Captures one received byte per transfer and holds it until the deframe
// step takes it; refills in the same cycle the held byte is taken.
// ----------------------------------------------------------------------------
module lpd_in_stage import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             byte_valid_o,
  input  logic             byte_take_i,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // Accept when empty or when the held byte leaves this cycle
  assign in_ready_o = !valid_q || byte_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (byte_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

/* design/lpd_deframe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_deframe: header collection and payload tagging
// Holds the framing state and the maximum-length register, and turns one
// byte into at most one result per cycle.
// ----------------------------------------------------------------------------
module lpd_deframe import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [LenW-1:0]  cfg_wr_data_i,
  input  logic             byte_valid_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             byte_take_o,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  logic [LenW-1:0]  max_len_q, max_len_d;
  logic [LenW-1:0]  hdr_acc_q, hdr_acc_d;
  logic [CntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0]  remain_q, remain_d;
  msg_class_e       class_q, class_d;
  logic             in_payload_q, in_payload_d;
  logic             halted_q, halted_d;

  logic [LenW-1:0]  acc_next;
  logic [CntW-1:0]  cnt_next;
  logic             first;
  logic             last;
  msg_class_e       cls;

  // Take a byte only when the result register can accept its outcome
  assign byte_take_o = byte_valid_i && res_ready_i;

  assign acc_next = {hdr_acc_q[LenW-ByteW-1:0], byte_i};
  assign cnt_next = hdr_cnt_q + 3'd1;
  assign first    = (hdr_cnt_q == HDR_LEN);
  assign last     = (remain_q <= 32'd1);

  // Decode the class from the first payload byte
  always_comb begin
    cls = class_q;
    if (first) begin
      case (byte_i)
        TYPE_META:  cls = CLASS_META;
        TYPE_CHUNK: cls = CLASS_CHUNK;
        default:    cls = CLASS_PLAIN;
      endcase
    end
  end

  // Next state and result
  always_comb begin
    max_len_d    = cfg_wr_en_i ? cfg_wr_data_i : max_len_q;
    hdr_acc_d    = hdr_acc_q;
    hdr_cnt_d    = hdr_cnt_q;
    remain_d     = remain_q;
    class_d      = class_q;
    in_payload_d = in_payload_q;
    halted_d     = halted_q;
    res_valid_o  = 1'b0;
    res_o        = '{payload_byte: '0, message_class: CLASS_META,
                     first_of_message: 1'b0, last_of_message: 1'b0, too_large: 1'b0};

    if (byte_take_o && !halted_q) begin
      if (!in_payload_q) begin
        hdr_acc_d = acc_next;
        hdr_cnt_d = cnt_next;
        if (cnt_next >= HDR_LEN) begin
          if (acc_next > max_len_q) begin
            // Oversized header: report once and halt
            halted_d             = 1'b1;
            hdr_acc_d            = '0;
            hdr_cnt_d            = '0;
            remain_d             = '0;
            res_valid_o          = 1'b1;
            res_o.too_large      = 1'b1;
          end else if (acc_next == '0) begin
            // Empty frame: drop and restart the header
            hdr_acc_d = '0;
            hdr_cnt_d = '0;
            remain_d  = '0;
          end else begin
            remain_d     = acc_next;
            in_payload_d = 1'b1;
          end
        end
      end else begin
        res_valid_o            = 1'b1;
        res_o.payload_byte     = byte_i;
        res_o.message_class    = cls;
        res_o.first_of_message = first;
        res_o.last_of_message  = last;
        if (first) begin
          class_d   = cls;
          hdr_cnt_d = '0;
          hdr_acc_d = '0;
        end
        if (last) begin
          hdr_acc_d    = '0;
          hdr_cnt_d    = '0;
          remain_d     = '0;
          in_payload_d = 1'b0;
        end else begin
          remain_d = remain_q - 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= RESET_MAX_LEN;
      hdr_acc_q    <= '0;
      hdr_cnt_q    <= '0;
      remain_q     <= '0;
      class_q      <= CLASS_PLAIN;
      in_payload_q <= 1'b0;
      halted_q     <= 1'b0;
    end else begin
      max_len_q    <= max_len_d;
      hdr_acc_q    <= hdr_acc_d;
      hdr_cnt_q    <= hdr_cnt_d;
      remain_q     <= remain_d;
      class_q      <= class_d;
      in_payload_q <= in_payload_d;
      halted_q     <= halted_d;
    end
  end

endmodule

/* design/lpd_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_out_stage: result register of the deframer
// Holds one result until the downstream side takes it; reloads in the same
// cycle the held result is transferred.
// ----------------------------------------------------------------------------
module lpd_out_stage import lpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  output logic    res_ready_o,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

/* design/length_prefix_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_deframer_top: length-prefixed frame splitter
// Takes one received byte per transfer, collects a 4-byte big-endian length
// header and passes the payload bytes out tagged with message class and
// first/last marks. The block sustains one byte per clock while the master
// side accepts every result: each byte passes an input register, one
// combinational deframe step and a result register, and a payload byte is
// presented on the master side from the result register. The slave side
// stalls only while a held result waits on the master side. Header bytes and
// empty frames give no output. A header above the maximum length gives one
// error transfer (too_large set, all else zero), after which every byte is
// taken and dropped until reset. Write the maximum only while idle; it
// resets to 10 MiB.
// ----------------------------------------------------------------------------
module length_prefix_deframer_top import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Maximum payload length register
  input  logic             cfg_wr_en_i,
  input  logic [LenW-1:0]  cfg_wr_data_i,
  // Received bytes
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
  // Payload bytes
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] payload_byte
  output logic [7:0]       m_axis_tuser,   // [1:0] message_class, [2] first_of_message,
                                           // [3] too_large, [7:4] zero
  output logic             m_axis_tlast    // last_of_message
);

  logic             byte_valid;
  logic             byte_take;
  logic [ByteW-1:0] byte_q;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          out;

  lpd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .byte_valid_o (byte_valid),
    .byte_take_i  (byte_take),
    .byte_o       (byte_q)
  );

  lpd_deframe u_deframe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .byte_valid_i  (byte_valid),
    .byte_i        (byte_q),
    .byte_take_o   (byte_take),
    .res_ready_i   (res_ready),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  lpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  // Pack the result onto the stream
  assign m_axis_tdata = out.payload_byte;
  assign m_axis_tuser = {4'b0000, out.too_large, out.first_of_message, out.message_class};
  assign m_axis_tlast = out.last_of_message;

endmodule

/* design/lpd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_checker: port-level checks of the deframer
// Watches the result stream for error-record shape, halt behaviour and
// stall stability.
// ----------------------------------------------------------------------------
module lpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [7:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // Error record carries nothing but the error flag
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |->
      m_axis_tdata == 8'h00 && m_axis_tuser[2:0] == 3'b000 && !m_axis_tlast)
    else $error("error record has non-zero fields");

  // No output follows an error transfer
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[3] |=> !m_axis_tvalid)
    else $error("output after error transfer");

  // Class code three is never produced and tuser[7:4] stays zero
  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1:0] != 2'b11 && m_axis_tuser[7:4] == 4'h0)
    else $error("bad message class or tuser padding");

  // Stalled result holds
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind length_prefix_deframer_top lpd_checker u_lpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
